FILE: hdl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg: shared types and constants for the sorted list unit
// Sizes, result status codes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package slid_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int POS_W       = 4;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // result tdata packing: status, position, count, smallest, largest
    localparam int OUT_BITS    = 2 + POS_W + CNT_W + 2 * VALUE_WIDTH;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_W        = ((VALUE_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } slid_status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } slid_kind_t;

    // broadcast to every cell for one request
    typedef struct packed {
        logic ins;  // insert commits this cycle
        logic del;  // delete commits this cycle
    } slid_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/slid_cell.sv
// ----------------------------------------------------------------------------
// slid_cell: one slot of the sorted list
// Holds one entry, compares it with the request value and shifts with its
// neighbors on insert (up) or delete (down).
// ----------------------------------------------------------------------------
`default_nettype none

module slid_cell
    import slid_pkg::*;
(
    input  wire logic                          aclk,
    input  wire slid_ctl_t                     ctl,
    input  wire logic                          valid,       // slot holds a live entry
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic signed [VALUE_WIDTH-1:0] left_entry,
    input  wire logic                          left_gt,
    input  wire logic signed [VALUE_WIDTH-1:0] right_entry,
    input  wire logic                          right_le,
    output logic signed [VALUE_WIDTH-1:0]      entry,
    output logic                               gt,          // value < entry
    output logic                               le,          // entry <= value
    output logic                               eq
);

    logic signed [VALUE_WIDTH-1:0] entry_reg;
    logic signed [VALUE_WIDTH-1:0] entry_next;
    logic                          lt_v;

    assign lt_v  = value < entry_reg;
    assign gt    = valid & lt_v;
    assign le    = valid & ~lt_v;
    assign eq    = valid & (entry_reg == value);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else if (gt || !valid) begin
                entry_next = value;
            end
        end else if (ctl.del) begin
            if (!right_le) begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: hdl/sorted_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit: bounded ascending list with insert/delete
// Accepted requests pass the pending stage, then the output register.
// Throughput: one request per cycle while the output is not stalled; the cell row updates in the accept cycle.
// Reset: aresetn (sync, active low) empties the list and drops both valids;
//   entry contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete_unit
    import slid_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // [31:0] value (signed)
    input  wire logic             s_tuser,   // [0] kind: 0 insert, 1 delete

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // [1:0] status, [5:2] position,
                                             // [10:6] count_after,
                                             // [42:11] smallest, [74:43] largest
);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                          s_accept;
    logic signed [VALUE_WIDTH-1:0] in_value;
    slid_kind_t                    in_kind;

    assign s_accept = s_tvalid & s_tready;
    assign in_value = signed'(s_tdata[VALUE_WIDTH-1:0]);
    assign in_kind  = slid_kind_t'(s_tuser);

    // ------------------------------------------------------------------
    // List state: entry count plus the row of cells
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic signed [VALUE_WIDTH-1:0] ent [CAPACITY];
    logic [CAPACITY-1:0]           gt_vec;
    logic [CAPACITY-1:0]           le_vec;
    logic [CAPACITY-1:0]           eq_vec;
    logic [CAPACITY-1:0]           valid_vec;
    slid_ctl_t                     ctl;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [VALUE_WIDTH-1:0] l_entry;
            logic                          l_gt;
            logic signed [VALUE_WIDTH-1:0] r_entry;
            logic                          r_le;

            assign valid_vec[gi] = count_reg > CNT_W'(gi);

            if (gi == 0) begin : g_first
                assign l_entry = in_value;
                assign l_gt    = 1'b0;
            end else begin : g_mid_l
                assign l_entry = ent[gi-1];
                assign l_gt    = gt_vec[gi-1];
            end

            // the top cell sees an empty slot above it
            if (gi == CAPACITY - 1) begin : g_last
                assign r_entry = ent[gi];
                assign r_le    = 1'b0;
            end else begin : g_mid_r
                assign r_entry = ent[gi+1];
                assign r_le    = le_vec[gi+1];
            end

            slid_cell u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .valid       (valid_vec[gi]),
                .value       (in_value),
                .left_entry  (l_entry),
                .left_gt     (l_gt),
                .right_entry (r_entry),
                .right_le    (r_le),
                .entry       (ent[gi]),
                .gt          (gt_vec[gi]),
                .le          (le_vec[gi]),
                .eq          (eq_vec[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Position and status. le_vec is a thermometer over live entries,
    // so its length is the insert slot; the last equal entry sits one
    // below it.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  n_le;
    logic              is_full;
    logic              is_empty;
    logic              found;
    slid_status_t      status_calc;
    logic [POS_W-1:0]  pos_calc;

    always_comb begin
        n_le = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (le_vec[i]) begin
                n_le = CNT_W'(i + 1);
            end
        end
    end

    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;
    assign found    = |eq_vec;

    always_comb begin
        status_calc = ST_DONE;
        pos_calc    = '0;
        ctl         = '0;
        count_next  = count_reg;
        case (in_kind)
            KIND_INSERT: begin
                if (is_full) begin
                    status_calc = ST_FULL;
                end else begin
                    pos_calc   = n_le[POS_W-1:0];
                    ctl.ins    = s_accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_DELETE: begin
                if (is_empty) begin
                    status_calc = ST_EMPTY;
                end else if (!found) begin
                    status_calc = ST_NOT_FOUND;
                end else begin
                    pos_calc   = POS_W'(n_le - CNT_W'(1));
                    ctl.del    = s_accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status_calc = ST_DONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pending stage: status and position are registered while the cells
    // settle, then merge with head/tail into the output register.
    // ------------------------------------------------------------------
    logic             pend_reg;
    slid_status_t     pend_status_reg;
    logic [POS_W-1:0] pend_pos_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             out_load;

    assign out_load = pend_reg & (~m_tvalid_reg | m_tready);
    assign s_tready = ~pend_reg | out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg <= count_next;
                pend_reg  <= 1'b1;
            end else if (out_load) begin
                pend_reg  <= 1'b0;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_status_reg <= status_calc;
            pend_pos_reg    <= pos_calc;
        end
    end

    // head and tail of the list as it stands after the pending request
    logic [POS_W-1:0]              tail_idx;
    logic signed [VALUE_WIDTH-1:0] head_val;
    logic signed [VALUE_WIDTH-1:0] tail_val;
    logic [OUT_BITS-1:0]           out_word;

    assign tail_idx = POS_W'(count_reg - CNT_W'(1));
    assign head_val = is_empty ? '0 : ent[0];
    assign tail_val = is_empty ? '0 : ent[tail_idx];
    assign out_word = {tail_val, head_val, count_reg, pend_pos_reg, pend_status_reg};

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= OUT_W'(out_word);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: verif/tb_sorted_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete_unit: self-checking bench for the sorted list
// Keeps a shadow copy of the list to predict the status, position, count and
// head/tail of every result. Runs directed corner cases first, then random
// fill/drain traffic under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------

module tb_sorted_list_insert_delete_unit;

    import slid_pkg::*;

    // result fields, lowest bits last, to line up with m_tdata
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] largest;
        logic signed [VALUE_WIDTH-1:0] smallest;
        logic [CNT_W-1:0]              count_after;
        logic [POS_W-1:0]              position;
        slid_status_t                  status;
    } list_outcome_t;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // [31:0] value (signed)
    logic             s_tuser;   // [0] kind
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // [1:0] status, [5:2] position, [10:6] count_after,
                                 // [42:11] smallest, [74:43] largest

    // shadow state of the list
    logic signed [VALUE_WIDTH-1:0] shadow_list [CAPACITY];
    int                            shadow_count = 0;

    list_outcome_t outcome_q [$];
    int            error_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    sorted_list_insert_delete_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // receiver backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // apply one request to the shadow list and return the expected result
    function automatic list_outcome_t apply_to_shadow_list(
        slid_kind_t kind, logic signed [VALUE_WIDTH-1:0] value);
        list_outcome_t r;
        int            p;
        int            i;
        logic          found;
        r = '0;
        r.status = ST_DONE;
        p = 0;
        found = 1'b0;
        if (kind == KIND_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // lands after every entry <= value
                while (p < shadow_count && !(value < shadow_list[p])) p++;
                for (i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
                shadow_list[p] = value;
                shadow_count++;
                r.position = POS_W'(p);
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                // highest matching index wins
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_list[i] == value) begin
                        found = 1'b1;
                        p = i;
                    end
                end
                if (!found) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    r.position = POS_W'(p);
                end
            end
        end
        r.count_after = CNT_W'(shadow_count);
        if (shadow_count != 0) begin
            r.smallest = shadow_list[0];
            r.largest  = shadow_list[shadow_count-1];
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input slid_kind_t kind,
                                input logic signed [VALUE_WIDTH-1:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(apply_to_shadow_list(kind, value));
        @(negedge aclk);
    endtask

    // sender holds off until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(7) - 4;          // tight pool -> duplicates
        if (r < 50) begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // result checker
    always @(posedge aclk) begin
        list_outcome_t want;
        list_outcome_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_BITS-1:0];
            if (outcome_q.size() == 0) begin
                $display("%0t: ERROR unexpected result, actual %h", $time, got);
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: ERROR status expected %0d actual %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.position !== want.position) begin
                    $display("%0t: ERROR position expected %0d actual %0d",
                             $time, want.position, got.position);
                    error_count++;
                end
                if (got.count_after !== want.count_after) begin
                    $display("%0t: ERROR count_after expected %0d actual %0d",
                             $time, want.count_after, got.count_after);
                    error_count++;
                end
                if (got.smallest !== want.smallest) begin
                    $display("%0t: ERROR smallest expected %0d actual %0d",
                             $time, want.smallest, got.smallest);
                    error_count++;
                end
                if (got.largest !== want.largest) begin
                    $display("%0t: ERROR largest expected %0d actual %0d",
                             $time, want.largest, got.largest);
                    error_count++;
                end
            end
        end
    end

    task automatic test_delete_empty();
        send_request(KIND_DELETE, 0);
    endtask

    // extremes plus an equal value that must land after the first zero
    task automatic test_insert_extremes();
        send_request(KIND_INSERT, VAL_MAX);
        send_request(KIND_INSERT, VAL_MIN);
        send_request(KIND_INSERT, 0);
        send_request(KIND_INSERT, -1);
        send_request(KIND_INSERT, 0);
    endtask

    // absent value, duplicate removal (highest index), head removal
    task automatic test_delete_cases();
        send_request(KIND_DELETE, 5);
        send_request(KIND_DELETE, 0);
        send_request(KIND_DELETE, VAL_MIN);
    endtask

    // fill to capacity, bounce off full, then drop the tail
    task automatic test_fill_to_full();
        while (shadow_count < CAPACITY) send_request(KIND_INSERT, $urandom);
        send_request(KIND_INSERT, 1);
        send_request(KIND_DELETE, VAL_MAX);
    endtask

    // alternating fill and drain bursts so the list hits full and empty
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        slid_kind_t                    kind;
        logic signed [VALUE_WIDTH-1:0] value;
        int                            ins_pct;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            ins_pct = ((i / 40) % 2 == 0) ? 80 : 20;
            kind = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_DELETE;
            if (kind == KIND_DELETE && shadow_count > 0 && $urandom_range(99) < 75)
                value = shadow_list[$urandom_range(shadow_count - 1)];
            else
                value = pick_value();
            send_request(kind, value);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_delete_empty();
        test_insert_extremes();
        test_delete_cases();
        test_fill_to_full();

        test_random_traffic(0, 0, 130);
        wait_drained();
        test_random_traffic(52, 0, 130);
        test_random_traffic(0, 52, 130);
        test_random_traffic(23, 23, 130);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hang guard
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sorted_list_insert_delete_unit.f
hdl/slid_pkg.sv
hdl/slid_cell.sv
hdl/sorted_list_insert_delete_unit.sv
verif/tb_sorted_list_insert_delete_unit.sv
